[hdl/m3i_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package m3i_pkg;

    // Element format: signed fixed point
    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int N_ELEM     = 9;
    localparam int N_ROW      = 3;

    // Internal widths, all exact (nothing wraps before saturation)
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int COF_W  = 2 * ELEM_WIDTH + 1;
    localparam int CMAG_W = 2 * ELEM_WIDTH;
    localparam int PART_W = 2 * ELEM_WIDTH + 1;
    localparam int TERM_W = 3 * ELEM_WIDTH + 2;
    localparam int DET_W  = 3 * ELEM_WIDTH + 4;
    localparam int DMAG_W = 3 * ELEM_WIDTH;
    localparam int REM_W  = DMAG_W + 1;
    localparam int NUM_W  = CMAG_W + 2 * FRAC_BITS;
    localparam int CMP_W  = (NUM_W > DMAG_W + ELEM_WIDTH) ? NUM_W : DMAG_W + ELEM_WIDTH;

    // Pipeline depths
    localparam int FRONT_LAT = 6;
    localparam int DIV_STEPS = ELEM_WIDTH;
    localparam int LANE_LAT  = DIV_STEPS + 2;
    localparam int DEN_TAPS  = DIV_STEPS + 2;

    typedef logic signed [ELEM_WIDTH-1:0] t_elem;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [COF_W-1:0]      t_cof;
    typedef logic signed [PART_W-1:0]     t_part;
    typedef logic signed [TERM_W-1:0]     t_term;
    typedef logic signed [DET_W-1:0]      t_det;
    typedef logic [CMAG_W-1:0]            t_cmag;
    typedef logic [DMAG_W-1:0]            t_dmag;

    typedef struct packed {
        logic valid;
        logic singular;
    } t_ctl;

    localparam t_elem ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam t_elem ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
    localparam logic [ELEM_WIDTH:0] POS_LIM = {2'b00, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic [ELEM_WIDTH:0] NEG_LIM = {2'b01, {(ELEM_WIDTH-1){1'b0}}};

    // Cofactor k (already in adjugate order) = +/-(e[A]*e[B] - e[C]*e[D])
    localparam int COF_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7}, '{1, 8, 2, 7}, '{1, 5, 2, 4},
        '{3, 8, 5, 6}, '{0, 8, 2, 6}, '{0, 5, 2, 3},
        '{3, 7, 4, 6}, '{0, 7, 1, 6}, '{0, 4, 1, 3}
    };
    localparam bit COF_NEG [N_ELEM] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

endpackage

`default_nettype wire

[hdl/m3i_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module m3i_front import m3i_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_elem i_a [N_ELEM],
    output t_ctl       o_ctl,
    output t_cmag      o_cmag [N_ELEM],
    output logic       o_neg [N_ELEM],
    output t_dmag      o_dmag
);

    logic  r_v [FRONT_LAT];
    t_prod r_p [2*N_ELEM];
    t_elem r_row1 [N_ROW];
    t_elem r_row2 [N_ROW];
    t_cof  r_cof2 [N_ELEM];
    t_cof  r_cof3 [N_ELEM];
    t_cof  r_cof4 [N_ELEM];
    t_cof  r_cof5 [N_ELEM];
    t_part r_lo [N_ROW];
    t_part r_hi [N_ROW];
    t_term r_term [N_ROW];
    t_det  r_det;
    t_cmag r_cmag [N_ELEM];
    logic  r_neg [N_ELEM];
    t_dmag r_dmag;
    logic  r_sing;
    t_det  det_abs;
    t_cof  cof_abs [N_ELEM];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < FRONT_LAT; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < FRONT_LAT; s++) r_v[s] <= r_v[s-1];
        end
    end

    assign det_abs = r_det[DET_W-1] ? -r_det : r_det;

    always_comb begin
        for (int k = 0; k < N_ELEM; k++) begin
            cof_abs[k] = r_cof5[k][COF_W-1] ? -r_cof5[k] : r_cof5[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // products for the 2x2 minors
            for (int k = 0; k < N_ELEM; k++) begin
                r_p[2*k]   <= i_a[COF_IDX[k][0]] * i_a[COF_IDX[k][1]];
                r_p[2*k+1] <= i_a[COF_IDX[k][2]] * i_a[COF_IDX[k][3]];
            end
            for (int r = 0; r < N_ROW; r++) begin
                r_row1[r] <= i_a[r];
                r_row2[r] <= r_row1[r];
            end
            // signed cofactors
            for (int k = 0; k < N_ELEM; k++) begin
                if (COF_NEG[k]) begin
                    r_cof2[k] <= COF_W'(r_p[2*k+1]) - COF_W'(r_p[2*k]);
                end else begin
                    r_cof2[k] <= COF_W'(r_p[2*k]) - COF_W'(r_p[2*k+1]);
                end
                r_cof3[k] <= r_cof2[k];
                r_cof4[k] <= r_cof3[k];
                r_cof5[k] <= r_cof4[k];
            end
            // first-row expansion, cofactor split into low and high halves
            for (int r = 0; r < N_ROW; r++) begin
                r_lo[r] <= r_row2[r] * $signed({1'b0, r_cof2[3*r][ELEM_WIDTH-1:0]});
                r_hi[r] <= r_row2[r] * $signed(r_cof2[3*r][COF_W-1:ELEM_WIDTH]);
                r_term[r] <= (TERM_W'(r_hi[r]) <<< ELEM_WIDTH) + TERM_W'(r_lo[r]);
            end
            r_det <= DET_W'(r_term[0]) + DET_W'(r_term[1]) + DET_W'(r_term[2]);
            // sign and magnitude split for the divider lanes
            for (int k = 0; k < N_ELEM; k++) begin
                r_cmag[k] <= cof_abs[k][CMAG_W-1:0];
                r_neg[k]  <= r_cof5[k][COF_W-1] ^ r_det[DET_W-1];
            end
            r_dmag <= det_abs[DMAG_W-1:0];
            r_sing <= (r_det == '0);
        end
    end

    assign o_ctl.valid    = r_v[FRONT_LAT-1];
    assign o_ctl.singular = r_sing;
    assign o_cmag = r_cmag;
    assign o_neg  = r_neg;
    assign o_dmag = r_dmag;

endmodule

`default_nettype wire

[hdl/m3i_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module m3i_lane import m3i_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_cmag i_cmag,
    input  wire logic  i_neg,
    input  wire t_dmag i_den [DEN_TAPS],
    output t_elem      o_val,
    output logic       o_ovf
);

    logic [NUM_W-1:0]      num;
    logic                  big;
    logic [REM_W-1:0]      r_rem [DIV_STEPS+1];
    logic [ELEM_WIDTH-1:0] r_q   [DIV_STEPS+1];
    logic [ELEM_WIDTH-1:0] r_nb  [DIV_STEPS+1];
    logic                  r_big [DIV_STEPS+1];
    logic                  r_sgn [DIV_STEPS+1];
    logic                  rnd;
    logic [ELEM_WIDTH:0]   qr;
    logic [ELEM_WIDTH:0]   qr_neg;
    logic                  sat;
    t_elem                 val;
    t_elem                 r_val;
    logic                  r_ovf;

    // numerator = |cofactor| scaled by 2^(2*FRAC_BITS)
    assign num = NUM_W'(i_cmag) << (2 * FRAC_BITS);
    // quotient would not fit in ELEM_WIDTH bits
    assign big = CMP_W'(num) >= (CMP_W'(i_den[0]) << ELEM_WIDTH);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= REM_W'(num >> ELEM_WIDTH);
            r_q[0]   <= '0;
            r_nb[0]  <= num[ELEM_WIDTH-1:0];
            r_big[0] <= big;
            r_sgn[0] <= i_neg;
        end
    end

    // one restoring quotient bit per stage
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] diff;
        logic             ge;

        assign trial = {r_rem[j][REM_W-2:0], r_nb[j][ELEM_WIDTH-1]};
        assign ge    = trial >= REM_W'(i_den[j+1]);
        assign diff  = trial - REM_W'(i_den[j+1]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= ge ? diff : trial;
                r_q[j+1]   <= {r_q[j][ELEM_WIDTH-2:0], ge};
                r_nb[j+1]  <= r_nb[j] << 1;
                r_big[j+1] <= r_big[j];
                r_sgn[j+1] <= r_sgn[j];
            end
        end
    end

    // round half away from zero, then saturate
    assign rnd    = {r_rem[DIV_STEPS][REM_W-2:0], 1'b0} >= REM_W'(i_den[DEN_TAPS-1]);
    assign qr     = {1'b0, r_q[DIV_STEPS]} + (ELEM_WIDTH+1)'(rnd);
    assign qr_neg = ~qr + 1'b1;

    always_comb begin
        if (r_sgn[DIV_STEPS]) begin
            sat = r_big[DIV_STEPS] || (qr > NEG_LIM);
            val = sat ? ELEM_MIN : t_elem'(qr_neg[ELEM_WIDTH-1:0]);
        end else begin
            sat = r_big[DIV_STEPS] || (qr > POS_LIM);
            val = sat ? ELEM_MAX : t_elem'(qr[ELEM_WIDTH-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= val;
            r_ovf <= sat;
        end
    end

    assign o_val = r_val;
    assign o_ovf = r_ovf;

endmodule

`default_nettype wire

[hdl/m3i_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

module m3i_merge import m3i_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire t_ctl  i_ctl,
    input  wire t_elem i_val [N_ELEM],
    input  wire logic  i_ovf [N_ELEM],
    output logic       o_valid,
    output t_elem      o_val [N_ELEM],
    output logic       o_singular,
    output logic       o_overflow
);

    logic  r_valid;
    t_elem r_val [N_ELEM];
    logic  r_sing;
    logic  r_ovf;
    logic  any_ovf;

    always_comb begin
        any_ovf = 1'b0;
        for (int k = 0; k < N_ELEM; k++) any_ovf = any_ovf | i_ovf[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    // zero determinant: drop the lane results
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sing <= i_ctl.singular;
            r_ovf  <= !i_ctl.singular && any_ovf;
            for (int k = 0; k < N_ELEM; k++) begin
                r_val[k] <= i_ctl.singular ? '0 : i_val[k];
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_val      = r_val;
    assign o_singular = r_sing;
    assign o_overflow = r_ovf;

endmodule

`default_nettype wire

[hdl/matrix3_inverse_unit.sv]
// Path from input accept to o_out_valid: 6 front stages for cofactors and
//   determinant, 34 lane stages (one quotient bit per stage plus setup and
//   rounding), 1 merge stage, 1 output register; each of the 9 divider lanes is fully pipelined.
// Throughput: one item per cycle while o_in_stall is low.
// Reset (synchronous, active low) clears valid bits and r_ctl; payload regs are not reset.
`timescale 1ns / 1ps
`default_nettype none

module matrix3_inverse_unit import m3i_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    input  wire t_elem i_a00,
    input  wire t_elem i_a01,
    input  wire t_elem i_a02,
    input  wire t_elem i_a10,
    input  wire t_elem i_a11,
    input  wire t_elem i_a12,
    input  wire t_elem i_a20,
    input  wire t_elem i_a21,
    input  wire t_elem i_a22,
    output logic       o_out_valid,
    input  wire logic  i_out_stall,
    output t_elem      o_b00,
    output t_elem      o_b01,
    output t_elem      o_b02,
    output t_elem      o_b10,
    output t_elem      o_b11,
    output t_elem      o_b12,
    output t_elem      o_b20,
    output t_elem      o_b21,
    output t_elem      o_b22,
    output logic       o_singular,
    output logic       o_overflow
);

    // Whole pipeline advances together while the skid entry is empty.
    logic  en;
    t_elem a_in [N_ELEM];

    t_ctl  f_ctl;
    t_cmag f_cmag [N_ELEM];
    logic  f_neg [N_ELEM];
    t_dmag f_dmag;

    // Divisor and control travel alongside the lanes, one copy shared by all nine.
    t_dmag r_den [DEN_TAPS-1];
    t_dmag den_tap [DEN_TAPS];
    t_ctl  r_ctl [LANE_LAT];

    t_elem l_val [N_ELEM];
    logic  l_ovf [N_ELEM];

    logic  m_valid;
    t_elem m_val [N_ELEM];
    logic  m_sing;
    logic  m_ovf;

    // Output register plus one skid entry.
    logic  r_out_valid;
    t_elem r_out_val [N_ELEM];
    logic  r_out_sing;
    logic  r_out_ovf;
    logic  r_skid_valid;
    t_elem r_skid_val [N_ELEM];
    logic  r_skid_sing;
    logic  r_skid_ovf;

    logic  take;
    logic  out_fire;
    logic  out_free;

    assign en         = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    assign a_in[0] = i_a00;
    assign a_in[1] = i_a01;
    assign a_in[2] = i_a02;
    assign a_in[3] = i_a10;
    assign a_in[4] = i_a11;
    assign a_in[5] = i_a12;
    assign a_in[6] = i_a20;
    assign a_in[7] = i_a21;
    assign a_in[8] = i_a22;

    // Cofactors, determinant, sign/magnitude split
    m3i_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_a     (a_in),
        .o_ctl   (f_ctl),
        .o_cmag  (f_cmag),
        .o_neg   (f_neg),
        .o_dmag  (f_dmag)
    );

    // Delay line for |det|: tap 0 feeds lane setup, tap j+1 feeds quotient step j,
    // the last tap feeds the rounding compare.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den[0] <= f_dmag;
            for (int s = 1; s < DEN_TAPS-1; s++) r_den[s] <= r_den[s-1];
        end
    end

    always_comb begin
        den_tap[0] = f_dmag;
        for (int s = 1; s < DEN_TAPS; s++) den_tap[s] = r_den[s-1];
    end

    // Valid and singular flag, matched to lane latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LANE_LAT; s++) r_ctl[s] <= '0;
        end else if (en) begin
            r_ctl[0] <= f_ctl;
            for (int s = 1; s < LANE_LAT; s++) r_ctl[s] <= r_ctl[s-1];
        end
    end

    // One divider lane per result element
    for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
        m3i_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_cmag (f_cmag[k]),
            .i_neg  (f_neg[k]),
            .i_den  (den_tap),
            .o_val  (l_val[k]),
            .o_ovf  (l_ovf[k])
        );
    end

    // Combine lane flags, zero the result for a singular matrix
    m3i_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_ctl      (r_ctl[LANE_LAT-1]),
        .i_val      (l_val),
        .i_ovf      (l_ovf),
        .o_valid    (m_valid),
        .o_val      (m_val),
        .o_singular (m_sing),
        .o_overflow (m_ovf)
    );

    // An item leaves the merge stage only on a cycle the pipeline advances.
    assign take     = m_valid && en;
    assign out_fire = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || out_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                // output held by the consumer: park the item
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid && out_free) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (out_free) begin
                r_out_val  <= m_val;
                r_out_sing <= m_sing;
                r_out_ovf  <= m_ovf;
            end else begin
                r_skid_val  <= m_val;
                r_skid_sing <= m_sing;
                r_skid_ovf  <= m_ovf;
            end
        end else if (r_skid_valid && out_free) begin
            r_out_val  <= r_skid_val;
            r_out_sing <= r_skid_sing;
            r_out_ovf  <= r_skid_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_b00 = r_out_val[0];
    assign o_b01 = r_out_val[1];
    assign o_b02 = r_out_val[2];
    assign o_b10 = r_out_val[3];
    assign o_b11 = r_out_val[4];
    assign o_b12 = r_out_val[5];
    assign o_b20 = r_out_val[6];
    assign o_b21 = r_out_val[7];
    assign o_b22 = r_out_val[8];
    assign o_singular = r_out_sing;
    assign o_overflow = r_out_ovf;

    // Skid entry is only ever filled behind an occupied output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall))
        else $error("skid entry filled while output was free");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not drained after output taken");

    a_singular_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sing) |-> (!r_out_ovf && r_out_val[0] == '0 && r_out_val[4] == '0))
        else $error("singular result carries overflow or nonzero elements");

endmodule

`default_nettype wire
